/* sv/clock_bitmap_window_counter_defines.svh */
// Assertion macros used by the checker of this block.
`ifndef CLOCK_BITMAP_WINDOW_COUNTER_DEFINES_SVH
`define CLOCK_BITMAP_WINDOW_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBWC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbwc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbwc: next-cycle check failed");

`endif

/* sv/cbwc_pkg.sv */
package cbwc_pkg;

  // Cell array geometry.
  localparam int CELLS       = 4096;
  localparam int LANES       = 32;
  localparam int CELL_W      = 8;
  localparam int COUNTER_MAX = 255;
  localparam int ROWS        = CELLS / LANES;
  localparam int LANE_W      = $clog2(LANES);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int IDX_W       = ROW_W + LANE_W;
  localparam int WIDTH_W     = $clog2(CELLS) + 1;
  localparam int WIDTH_STEP  = 16;

  // Insert indices.
  localparam int MAX_HASHES  = 4;
  localparam int NUM_INDEX   = 4;
  localparam int KSEL_W      = $clog2(NUM_INDEX);
  localparam int HASH_W      = 3;

  // Sweep arithmetic.
  localparam int SWEEP_W       = 20;
  localparam int COUNT_W       = 10;
  localparam int AMT_W         = SWEEP_W + COUNT_W;
  localparam int GRANULE_SHIFT = 5;
  localparam int DIV_CNT_W     = $clog2(AMT_W);
  localparam int DEC_CAP       = COUNTER_MAX + 1;
  localparam int DEC_W         = $clog2(COUNTER_MAX + 3);

  // Configuration port.
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_WIDTH = 2'd0,
    REG_HASH_COUNT   = 2'd1,
    REG_SWEEP_LENGTH = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DIV_HAND,
    ST_DIV_AMT,
    ST_SWEEP,
    ST_RESULT
  } state_e;

  // One memory row: one cell per lane.
  typedef logic [LANES-1:0][CELL_W-1:0] word_t;

  // What every lane needs to age the cells of one row.
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [IDX_W-1:0]   hand;
    logic [WIDTH_W-1:0] rem;
    logic [DEC_W-1:0]   qsat;
    logic [ROW_W-1:0]   row;
  } sweep_ctl_t;

endpackage

/* sv/clock_bitmap_window_counter.sv */
// Channel   Handshake                 Payload
// command   start / busy              opcode_i, index_a_i..index_d_i, insert_count_i
// result    done_o (one-cycle strobe) zero_count_o
// config    cfg_we_i, cfg_idx_i       cfg_wdata_i
//
// Cells live in 128 rows of 32 lanes; one row passes through the lanes per cycle,
// so the single read port of the cell memory sets the sweep rate.
// A query sweeps the active rows. An advance first runs two 30-step divisions, which
// reduce the hand and split the sweep amount, and then sweeps the active rows.
// An insert reads and rewrites the row of each in-range index in turn.
// After reset all cells read as zero at once; no clearing pass is needed.
// The receiver cannot stall: a result is shown for one cycle only.
module clock_bitmap_window_counter
  import cbwc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode_i,
  input  logic [IDX_W-1:0]     index_a_i,
  input  logic [IDX_W-1:0]     index_b_i,
  input  logic [IDX_W-1:0]     index_c_i,
  input  logic [IDX_W-1:0]     index_d_i,
  input  logic [COUNT_W-1:0]   insert_count_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic [WIDTH_W-1:0]   zero_count_o
);

  state_e state_q, state_d;

  // Configuration registers.
  logic [WIDTH_W-1:0] active_width_q;
  logic [HASH_W-1:0]  hash_count_q;
  logic [SWEEP_W-1:0] sweep_length_q;

  // Command registers.
  op_e                op_q;
  logic [IDX_W-1:0]   idx_q [NUM_INDEX];
  logic [HASH_W-1:0]  n_q;
  logic [HASH_W-1:0]  k_q;
  logic [WIDTH_W-1:0] w_q;
  logic [ROW_W:0]     rows_q;
  logic [AMT_W-1:0]   amount_q;
  logic [IDX_W-1:0]   hand_position_q;
  logic [IDX_W-1:0]   hand_q;
  logic [WIDTH_W-1:0] r_q;
  logic [DEC_W-1:0]   qsat_q;
  logic [ROW_W:0]     rd_row_q;
  logic               p1_valid_q;
  logic [ROW_W-1:0]   p1_row_q;

  logic               accept;
  logic [WIDTH_W-1:0] w_masked, eff_w;
  logic [HASH_W-1:0]  eff_n;
  logic [AMT_W-1:0]   prod, amount_d;
  logic [WIDTH_W:0]   rows_sum;
  logic [IDX_W-1:0]   idx_sel;
  logic               idx_ok;
  logic               sweep_end;
  logic [WIDTH_W-1:0] hand_sum, hand_next;
  logic [DEC_W-1:0]   qsat_d;

  // Memory, divider and lane connections.
  logic               rd_en, wr_en;
  logic [ROW_W-1:0]   rd_addr, wr_addr;
  word_t              rd_data, wr_data, aged_word, ins_word;
  logic               div_start, div_done;
  logic [AMT_W-1:0]   div_dividend, div_quot;
  logic [WIDTH_W-1:0] div_rem;
  sweep_ctl_t         sweep_ctl;
  logic [LANES-1:0]   lane_zero;
  logic [WIDTH_W-1:0] merge_count;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Effective width, hash count and sweep amount from the registers.
  always_comb begin
    w_masked = active_width_q & ~WIDTH_W'(WIDTH_STEP - 1);
    if (w_masked < WIDTH_W'(WIDTH_STEP)) begin
      eff_w = WIDTH_W'(WIDTH_STEP);
    end else if (w_masked > WIDTH_W'(CELLS)) begin
      eff_w = WIDTH_W'(CELLS);
    end else begin
      eff_w = w_masked;
    end
    eff_n    = (hash_count_q > HASH_W'(MAX_HASHES)) ? HASH_W'(MAX_HASHES) : hash_count_q;
    prod     = AMT_W'(sweep_length_q) * AMT_W'(insert_count_i);
    amount_d = (prod >> GRANULE_SHIFT) << GRANULE_SHIFT;
    rows_sum = {1'b0, eff_w} + (WIDTH_W + 1)'(LANES - 1);
  end

  // Insert index selection and range check.
  assign idx_sel = idx_q[k_q[KSEL_W-1:0]];
  assign idx_ok  = {1'b0, idx_sel} < w_q;

  assign sweep_end = (rd_row_q == rows_q) && !p1_valid_q;

  // Hand after an advance: (hand + R) mod W with hand and R both below W.
  always_comb begin
    hand_sum  = {1'b0, hand_q} + r_q;
    hand_next = (hand_sum >= w_q) ? hand_sum - w_q : hand_sum;
    qsat_d    = (div_quot >= AMT_W'(DEC_CAP)) ? DEC_W'(DEC_CAP) : div_quot[DEC_W-1:0];
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_width_q <= WIDTH_W'(CELLS);
      hash_count_q   <= HASH_W'(MAX_HASHES);
      sweep_length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ACTIVE_WIDTH: active_width_q <= cfg_wdata_i[WIDTH_W-1:0];
        REG_HASH_COUNT:   hash_count_q   <= cfg_wdata_i[HASH_W-1:0];
        REG_SWEEP_LENGTH: sweep_length_q <= cfg_wdata_i[SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(opcode_i))
            OP_INSERT:  state_d = ST_INS_RD;
            OP_ADVANCE: state_d = ST_DIV_HAND;
            OP_QUERY:   state_d = ST_SWEEP;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD: begin
        if (k_q >= n_q) begin
          state_d = ST_IDLE;
        end else if (idx_ok) begin
          state_d = ST_INS_WR;
        end
      end
      ST_INS_WR:   state_d = ST_INS_RD;
      ST_DIV_HAND: if (div_done) state_d = ST_DIV_AMT;
      ST_DIV_AMT:  if (div_done) state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (sweep_end) begin
          state_d = (op_q == OP_QUERY) ? ST_RESULT : ST_IDLE;
        end
      end
      ST_RESULT:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Insert write data: the read row with one cell set to the maximum.
  always_comb begin
    ins_word = rd_data;
    ins_word[idx_sel[LANE_W-1:0]] = CELL_W'(COUNTER_MAX);
  end

  // Control outputs of the sequencer.
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = rd_row_q[ROW_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = p1_row_q;
    wr_data      = aged_word;
    div_start    = 1'b0;
    div_dividend = amount_q;
    done_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        div_start    = accept && (op_e'(opcode_i) == OP_ADVANCE);
        div_dividend = AMT_W'(hand_position_q);
      end
      ST_INS_RD: begin
        rd_en   = (k_q < n_q) && idx_ok;
        rd_addr = idx_sel[IDX_W-1:LANE_W];
      end
      ST_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_sel[IDX_W-1:LANE_W];
        wr_data = ins_word;
      end
      ST_DIV_HAND: div_start = div_done;
      ST_DIV_AMT:  ;
      ST_SWEEP: begin
        rd_en = rd_row_q < rows_q;
        wr_en = p1_valid_q && (op_q == OP_ADVANCE);
      end
      ST_RESULT:   done_o = 1'b1;
      default:     ;
    endcase
  end

  // Sequencer counters and the hand.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q             <= '0;
      rd_row_q        <= '0;
      p1_valid_q      <= 1'b0;
      hand_position_q <= '0;
    end else begin
      if (accept) begin
        k_q        <= '0;
        rd_row_q   <= '0;
        p1_valid_q <= 1'b0;
      end
      if ((state_q == ST_INS_RD && k_q < n_q && !idx_ok) || state_q == ST_INS_WR) begin
        k_q <= k_q + 1'b1;
      end
      if (state_q == ST_SWEEP) begin
        p1_valid_q <= rd_en;
        if (rd_en) begin
          rd_row_q <= rd_row_q + 1'b1;
        end
        if (sweep_end && op_q == OP_ADVANCE) begin
          hand_position_q <= hand_next[IDX_W-1:0];
        end
      end
    end
  end

  // Command payload and division results.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_e'(opcode_i);
      idx_q[0] <= index_a_i;
      idx_q[1] <= index_b_i;
      idx_q[2] <= index_c_i;
      idx_q[3] <= index_d_i;
      n_q      <= eff_n;
      w_q      <= eff_w;
      rows_q   <= rows_sum[ROW_W+LANE_W:LANE_W];
      amount_q <= amount_d;
    end
    if (state_q == ST_DIV_HAND && div_done) begin
      hand_q <= div_rem[IDX_W-1:0];
    end
    if (state_q == ST_DIV_AMT && div_done) begin
      r_q    <= div_rem;
      qsat_q <= qsat_d;
    end
    if (state_q == ST_SWEEP) begin
      p1_row_q <= rd_row_q[ROW_W-1:0];
    end
  end

  cbwc_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  cbwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (eff_w),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign sweep_ctl.width = w_q;
  assign sweep_ctl.hand  = hand_q;
  assign sweep_ctl.rem   = r_q;
  assign sweep_ctl.qsat  = qsat_q;
  assign sweep_ctl.row   = p1_row_q;

  // One lane per cell of a row.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    cbwc_lane u_lane (
      .ctl_i  (sweep_ctl),
      .lane_i (LANE_W'(g)),
      .cell_i (rd_data[g]),
      .cell_o (aged_word[g]),
      .zero_o (lane_zero[g])
    );
  end

  cbwc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (accept),
    .flags_valid_i (p1_valid_q && (op_q == OP_QUERY)),
    .flags_i       (lane_zero),
    .count_o       (merge_count)
  );

  assign zero_count_o = merge_count;

endmodule

/* sv/cbwc_mem.sv */
module cbwc_mem
  import cbwc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [ROW_W-1:0] rd_addr_i,
  output word_t            rd_data_o,
  input  logic             wr_en_i,
  input  logic [ROW_W-1:0] wr_addr_i,
  input  word_t            wr_data_i
);

  word_t            mem_q [ROWS];
  word_t            rd_word_q;
  logic             rd_valid_q;
  logic [ROWS-1:0]  row_valid_q;

  // Cell storage, one row written per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_word_q <= mem_q[rd_addr_i];
    end
  end

  // A row that was never written since reset reads as all zero cells.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_word_q : '0;

endmodule

/* sv/cbwc_div.sv */
module cbwc_div
  import cbwc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AMT_W-1:0]   dividend_i,
  input  logic [WIDTH_W-1:0] divisor_i,
  output logic               done_o,
  output logic [AMT_W-1:0]   quot_o,
  output logic [WIDTH_W-1:0] rem_o
);

  localparam logic [DIV_CNT_W-1:0] CntLast = DIV_CNT_W'(AMT_W - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [AMT_W-1:0]     quo_q, quo_d;
  logic [WIDTH_W-1:0]   rem_q, rem_d;
  logic [WIDTH_W-1:0]   dvs_q;
  logic [WIDTH_W:0]     trial;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[AMT_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = WIDTH_W'(trial - {1'b0, dvs_q});
      quo_d = {quo_q[AMT_W-2:0], 1'b1};
    end else begin
      rem_d = trial[WIDTH_W-1:0];
      quo_d = {quo_q[AMT_W-2:0], 1'b0};
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CntLast);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

/* sv/cbwc_lane.sv */
module cbwc_lane
  import cbwc_pkg::*;
(
  input  sweep_ctl_t        ctl_i,
  input  logic [LANE_W-1:0] lane_i,
  input  logic [CELL_W-1:0] cell_i,
  output logic [CELL_W-1:0] cell_o,
  output logic              zero_o
);

  logic [WIDTH_W-1:0] idx;
  logic [WIDTH_W-1:0] hand_x;
  logic [WIDTH_W-1:0] off;
  logic               in_range;
  logic [DEC_W-1:0]   dec;

  // Position of this cell counted from the hand, wrapping at the width.
  always_comb begin
    idx      = {1'b0, ctl_i.row, lane_i};
    hand_x   = {1'b0, ctl_i.hand};
    in_range = idx < ctl_i.width;
    if (idx >= hand_x) begin
      off = idx - hand_x;
    end else begin
      off = idx + ctl_i.width - hand_x;
    end
    dec = ctl_i.qsat + DEC_W'(off < ctl_i.rem);
  end

  // Saturating decrement; cells beyond the width stay as they are.
  always_comb begin
    if (!in_range) begin
      cell_o = cell_i;
    end else if (dec >= DEC_W'(cell_i)) begin
      cell_o = '0;
    end else begin
      cell_o = cell_i - dec[CELL_W-1:0];
    end
  end

  assign zero_o = in_range && (cell_i == '0);

endmodule

/* sv/cbwc_merge.sv */
module cbwc_merge
  import cbwc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               flags_valid_i,
  input  logic [LANES-1:0]   flags_i,
  output logic [WIDTH_W-1:0] count_o
);

  logic [LANES-1:0]     flags_q;
  logic                 flags_valid_q;
  logic [WIDTH_W-1:0]   acc_q;
  logic [LANE_W:0]      pc;

  // Number of zero cells the lanes found in the registered row.
  always_comb begin
    pc = '0;
    for (int i = 0; i < LANES; i++) begin
      pc = pc + (LANE_W + 1)'(flags_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_valid_q <= 1'b0;
      acc_q         <= '0;
    end else begin
      flags_valid_q <= flags_valid_i;
      if (clear_i) begin
        acc_q <= '0;
      end else if (flags_valid_q) begin
        acc_q <= acc_q + WIDTH_W'(pc);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_i;
  end

  assign count_o = acc_q;

endmodule

/* sv/cbwc_checker.sv */
`include "clock_bitmap_window_counter_defines.svh"

module cbwc_checker
  import cbwc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           opcode_i,
  input logic [IDX_W-1:0]     index_a_i,
  input logic [IDX_W-1:0]     index_b_i,
  input logic [IDX_W-1:0]     index_c_i,
  input logic [IDX_W-1:0]     index_d_i,
  input logic [COUNT_W-1:0]   insert_count_i,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [CFG_W-1:0]     cfg_wdata_i,
  input logic                 done_o,
  input logic [WIDTH_W-1:0]   zero_count_o
);

  logic take_query, take_unused;

  assign take_query  = start && !busy && (opcode_i == OP_QUERY);
  assign take_unused = start && !busy && (opcode_i != OP_INSERT) &&
                       (opcode_i != OP_ADVANCE) && (opcode_i != OP_QUERY);

  // A result only ends a command that was in progress.
  `CBWC_ASSERT_IMPL(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy))
  // At a result the zero count does not exceed the number of cells.
  `CBWC_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, done_o, zero_count_o <= WIDTH_W'(CELLS))
  // A query sweeps the cells before any result appears.
  `CBWC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, take_query, busy && !done_o)
  // An unused opcode is dropped without starting work.
  `CBWC_ASSERT_NEXT(a_unused_idle, clk_i, rst_ni, take_unused, !busy)
  // After the result transfer the block is idle again.
  `CBWC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o && !busy)

endmodule

bind clock_bitmap_window_counter cbwc_checker u_checker (.*);
